// File: sv/ffca_pkg.sv
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared types and codes for the first-fit cell allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

   localparam int POOL_CELLS_DEF = 256;

   // index / count width, large enough for the largest pool size and for
   // a release end of start + length
   localparam int IDX_W = 17;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [1:0]       status_type;

   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_TOO_BIG = 2'd1;
   localparam status_type STATUS_NO_ROOM = 2'd2;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // scan token handed from cell to cell: free run length seen so far
   typedef struct packed {
      logic    valid;
      idx_type count;
   } token_type;

   // range write broadcast to all cells
   typedef struct packed {
      logic    en;
      logic    val;
      idx_type lo;
      idx_type hi;
   } mark_type;

endpackage

// File: sv/ffca_cell.sv
// ----------------------------------------------------------------------------
// ffca_cell
// One pool cell: occupancy bit, range write, and one stage of the scan chain.
// ----------------------------------------------------------------------------
module ffca_cell (
   input  logic                clock,
   input  logic                reset,
   input  ffca_pkg::idx_type   cell_idx,
   input  ffca_pkg::idx_type   run_len,
   input  ffca_pkg::mark_type  mark,
   input  ffca_pkg::token_type tok_prev,
   output ffca_pkg::token_type tok_next,
   output logic                hit
);
   import ffca_pkg::*;

   logic      busy_ff;
   logic      busy_in;
   token_type tok_ff;
   token_type tok_in;
   idx_type   run_cnt;

   always_comb begin
      run_cnt      = busy_ff ? '0 : idx_type'(tok_prev.count + 1'b1);
      hit          = tok_prev.valid && !busy_ff && (run_cnt == run_len);
      tok_in.valid = tok_prev.valid && !hit;
      tok_in.count = run_cnt;
      busy_in      = busy_ff;
      if (mark.en && (cell_idx >= mark.lo) && (cell_idx <= mark.hi)) begin
         busy_in = mark.val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         tok_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         tok_ff  <= tok_in;
      end
   end

   assign tok_next = tok_ff;

endmodule

// File: sv/first_fit_cell_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_cell_allocator
// First-fit contiguous allocator over a pool of occupancy cells.
// ----------------------------------------------------------------------------
// One request is handled at a time. An allocation sends a token down the chain
// of cells, one cell per cycle, counting free cells; it stops at the first
// cell that completes a run of the requested length, so the time an
// allocation takes is set by the position of the run end in the chain.
// Releases, oversized and zero-length requests skip the scan. Marking or
// clearing a run is a single-cycle write into all cells in range. The
// response register lets a new request enter while the last response is
// still stalled. All cells are free after reset.
module first_fit_cell_allocator #(
   parameter int POOL_CELLS = ffca_pkg::POOL_CELLS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_func,
   input  logic [15:0]          req_run_length,
   input  logic [7:0]           req_run_start,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ffca_pkg::status_type rsp_status,
   output logic [7:0]           rsp_granted_start
);
   import ffca_pkg::*;

   localparam int      POS_W     = $clog2(POOL_CELLS);
   localparam idx_type POOL_SIZE = idx_type'(POOL_CELLS);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]       state_ff,   state_in;
   logic [POS_W-1:0] pos_ff,     pos_in;
   logic             inject_ff,  inject_in;
   idx_type          len_ff,     len_in;
   mark_type         mark_ff,    mark_in;
   status_type       res_status_ff, res_status_in;
   logic [7:0]       res_start_ff,  res_start_in;
   logic             rsp_valid_ff,  rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [7:0]       rsp_start_ff,  rsp_start_in;

   token_type              tok_head;
   token_type              tok_chain [POOL_CELLS];
   logic [POOL_CELLS-1:0]  hits;

   logic    req_accept;
   logic    out_free;
   logic    hit_any;
   idx_type len_ext;
   idx_type rel_hi;
   idx_type scan_lo;

   assign tok_head.valid = inject_ff;
   assign tok_head.count = '0;

   for (genvar i = 0; i < POOL_CELLS; i++) begin : g_cell
      if (i == 0) begin : g_first
         ffca_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .cell_idx (idx_type'(i)),
            .run_len  (len_ff),
            .mark     (mark_ff),
            .tok_prev (tok_head),
            .tok_next (tok_chain[i]),
            .hit      (hits[i])
         );
      end else begin : g_rest
         ffca_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .cell_idx (idx_type'(i)),
            .run_len  (len_ff),
            .mark     (mark_ff),
            .tok_prev (tok_chain[i-1]),
            .tok_next (tok_chain[i]),
            .hit      (hits[i])
         );
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign hit_any    = |hits;
   assign len_ext    = idx_type'(req_run_length);
   assign rel_hi     = idx_type'(idx_type'(req_run_start) + len_ext - 1'b1);
   assign scan_lo    = idx_type'(idx_type'(pos_ff) - len_ff + 1'b1);

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      inject_in     = 1'b0;
      len_in        = len_ff;
      mark_in       = mark_ff;
      mark_in.en    = 1'b0;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               len_in        = len_ext;
               res_status_in = STATUS_OK;
               res_start_in  = '0;
               if (req_func == FUNC_FREE) begin
                  mark_in.en  = (len_ext != '0);
                  mark_in.val = 1'b0;
                  mark_in.lo  = idx_type'(req_run_start);
                  mark_in.hi  = rel_hi;
                  state_in    = ST_FINISH;
               end else if (len_ext > POOL_SIZE) begin
                  res_status_in = STATUS_TOO_BIG;
                  state_in      = ST_FINISH;
               end else if (len_ext == '0) begin
                  res_status_in = STATUS_NO_ROOM;
                  state_in      = ST_FINISH;
               end else begin
                  pos_in    = '0;
                  inject_in = 1'b1;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            pos_in = POS_W'(pos_ff + 1'b1);
            if (hit_any) begin
               mark_in.en   = 1'b1;
               mark_in.val  = 1'b1;
               mark_in.lo   = scan_lo;
               mark_in.hi   = idx_type'(pos_ff);
               res_start_in = scan_lo[7:0];
               state_in     = ST_FINISH;
            end else if (tok_chain[POOL_CELLS-1].valid) begin
               res_status_in = STATUS_NO_ROOM;
               state_in      = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_start_in  = res_start_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         inject_ff    <= 1'b0;
         mark_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         inject_ff    <= inject_in;
         mark_ff      <= mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      len_ff        <= len_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_start = rsp_start_ff;

endmodule

// File: sv/ffca_checker.sv
// ----------------------------------------------------------------------------
// ffca_checker
// Port-level checks for the first-fit cell allocator.
// ----------------------------------------------------------------------------
module ffca_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input ffca_pkg::status_type rsp_status,
   input logic [7:0]           rsp_granted_start
);
   import ffca_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
                                 && $stable(rsp_granted_start))
      else $error("stalled response changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK) || (rsp_status == STATUS_TOO_BIG)
                    || (rsp_status == STATUS_NO_ROOM))
      else $error("undefined status code");

   a_fail_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_granted_start == 8'd0)
      else $error("failed request carries a start cell");

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");

endmodule

bind first_fit_cell_allocator ffca_checker u_ffca_checker (.*);
